// File: hdl/erta_pkg.sv
// shared types and constants of the echo range trimmed average block
package erta_pkg;

   // field and datapath widths fixed by the word formats
   localparam int STAMP_W   = 64;
   localparam int NUM_W     = 8;
   localparam int TPU_W     = 16;
   localparam int COUNT_W   = 9;
   localparam int OUT_W     = 12;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;

   // divisor is ticks_per_us * 58, at most 58 * 65535 < 2**22
   localparam int DIV_W      = 22;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_CYCLES = STAMP_W / DIV_STEPS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   localparam int CM_DIVISOR = 58;
   localparam int OUT_LIMIT  = 4095;

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_AVG_COUNT    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_US = 8'd1;
   localparam logic [NUM_W-1:0]     AVG_COUNT_RST    = 8'd1;
   localparam logic [TPU_W-1:0]     TICKS_PER_US_RST = 16'd400;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIST,
      ST_UPDATE,
      ST_CHECK,
      ST_AVG,
      ST_EMIT
   } state_type;

endpackage

// File: hdl/echo_range_trimmed_average_top.sv
// echo range trimmed average: sequencer, shared iterative divider and window state
// usage
//   req_ channel: one word per sample slot, rising and falling echo stamps.
//   a slot with a zero stamp or falling before rising is counted but gives
//   no distance. every avg_count+2 slots (3 if avg_count is 0) one rsp_ word is
//   emitted: window distance sum less smallest and largest, divided by avg_count.
//   csr_ channel: index 0 avg_count, index 1 ticks_per_us, always ready;
//   write only while the block is idle.
// timing
//   one shared radix-16 restoring divider, 4 quotient bits a cycle, sets the
//   rate. a valid slot passes the divide by 58*ticks_per_us, the update and
//   the window check before req_ready again, a skipped slot only update and
//   check. the closing slot adds the average division (none when too few) and
//   the load of the output register before rsp_valid.
// reset
//   synchronous active-high reset: avg_count 1, ticks_per_us 400, window
//   cleared, no word pending on the output.
// stall
//   the result sits in an output register; the next slot is accepted while it
//   waits. only when a further result is ready does the sequencer hold.
module echo_range_trimmed_average_top #(
   parameter int MAX_DISTANCE_CM = 4095
) (
   input  logic                               clock,
   input  logic                               reset,
   // sample slot input
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [erta_pkg::STAMP_W-1:0]       req_rising_stamp,
   input  logic [erta_pkg::STAMP_W-1:0]       req_falling_stamp,
   // result output
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [erta_pkg::OUT_W-1:0]         rsp_distance_cm,
   output logic [erta_pkg::COUNT_W-1:0]       rsp_valid_samples,
   output logic                               rsp_too_few,
   // register write port
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [erta_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [erta_pkg::CSR_DAT_W-1:0]     csr_data
);

   // distance and sum widths follow from the saturation limit
   localparam int DIST_W = $clog2(MAX_DISTANCE_CM + 1);
   localparam int SUM_W  = DIST_W + erta_pkg::COUNT_W;
   localparam int STW    = erta_pkg::STAMP_W;
   localparam int DVW    = erta_pkg::DIV_W;
   localparam int CNW    = erta_pkg::COUNT_W;

   // configuration
   logic [erta_pkg::NUM_W-1:0] avg_count_ff;
   logic [erta_pkg::TPU_W-1:0] ticks_per_us_ff;
   logic [erta_pkg::NUM_W-1:0] n_eff;
   logic [erta_pkg::TPU_W-1:0] tpu_eff;

   // sequencer
   erta_pkg::state_type state_ff, state_in;

   // window state
   logic [CNW-1:0]    slot_count_ff, slot_count_in;
   logic [SUM_W-1:0]  running_sum_ff, running_sum_in;
   logic [DIST_W-1:0] smallest_ff, smallest_in;
   logic [DIST_W-1:0] largest_ff, largest_in;
   logic [CNW-1:0]    good_count_ff, good_count_in;
   logic              slot_good_ff, slot_good_in;
   logic              few_ff, few_in;

   // shared divider: quotient register shifts the dividend out at the top
   logic [STW-1:0]                    div_quo_ff, div_quo_in;
   logic [DVW-1:0]                    div_rem_ff, div_rem_in;
   logic [DVW-1:0]                    div_dsr_ff, div_dsr_in;
   logic [erta_pkg::DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic [STW-1:0]                    step_quo;
   logic [DVW-1:0]                    step_rem;
   logic [DVW:0]                      step_part;
   logic                              div_last;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [erta_pkg::OUT_W-1:0]    rsp_dist_ff, rsp_dist_in;
   logic [CNW-1:0]                rsp_count_ff, rsp_count_in;
   logic                          rsp_few_ff, rsp_few_in;

   // datapath helpers
   logic                  req_fire;
   logic                  stamps_good;
   logic [DIST_W-1:0]     dist_sat;
   logic [erta_pkg::OUT_W-1:0] avg_sat;
   logic                  window_closed;
   logic [SUM_W-1:0]      trimmed;
   logic                  out_free;

   assign req_ready = (state_ff == erta_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign n_eff   = (avg_count_ff == '0) ? erta_pkg::NUM_W'(1) : avg_count_ff;
   assign tpu_eff = (ticks_per_us_ff == '0) ? erta_pkg::TPU_W'(1) : ticks_per_us_ff;

   assign stamps_good = (req_rising_stamp != '0) && (req_falling_stamp != '0)
                        && (req_falling_stamp >= req_rising_stamp);

   // floor(floor(diff/t)/58) equals floor(diff/(58*t))
   assign dist_sat = ((|div_quo_ff[STW-1:DIST_W])
                      || (div_quo_ff[DIST_W-1:0] > DIST_W'(MAX_DISTANCE_CM)))
                     ? DIST_W'(MAX_DISTANCE_CM) : div_quo_ff[DIST_W-1:0];

   assign avg_sat = (|div_quo_ff[STW-1:erta_pkg::OUT_W])
                    ? erta_pkg::OUT_W'(erta_pkg::OUT_LIMIT)
                    : div_quo_ff[erta_pkg::OUT_W-1:0];

   assign window_closed = ({1'b0, slot_count_ff})
                          >= ({2'b00, n_eff} + (CNW + 1)'(2));
   assign trimmed  = running_sum_ff - SUM_W'(smallest_ff) - SUM_W'(largest_ff);
   assign div_last = (div_cnt_ff == erta_pkg::DIV_CNT_W'(erta_pkg::DIV_CYCLES - 1));
   assign out_free = !rsp_valid_ff || rsp_ready;

   // four restoring steps per cycle on the narrow remainder
   always_comb begin
      step_rem  = div_rem_ff;
      step_quo  = div_quo_ff;
      step_part = '0;
      for (int i = 0; i < erta_pkg::DIV_STEPS; i++) begin
         step_part = {step_rem, step_quo[STW-1]};
         step_quo  = {step_quo[STW-2:0], 1'b0};
         if (step_part >= {1'b0, div_dsr_ff}) begin
            step_part   = step_part - {1'b0, div_dsr_ff};
            step_quo[0] = 1'b1;
         end
         step_rem = step_part[DVW-1:0];
      end
   end

   // sequencer and datapath next values
   always_comb begin
      state_in       = state_ff;
      slot_count_in  = slot_count_ff;
      running_sum_in = running_sum_ff;
      smallest_in    = smallest_ff;
      largest_in     = largest_ff;
      good_count_in  = good_count_ff;
      slot_good_in   = slot_good_ff;
      few_in         = few_ff;
      div_quo_in     = div_quo_ff;
      div_rem_in     = div_rem_ff;
      div_dsr_in     = div_dsr_ff;
      div_cnt_in     = div_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_dist_in    = rsp_dist_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_few_in     = rsp_few_ff;

      case (state_ff)
         erta_pkg::ST_IDLE: begin
            if (req_fire) begin
               slot_good_in = stamps_good;
               div_quo_in   = req_falling_stamp - req_rising_stamp;
               div_rem_in   = '0;
               div_dsr_in   = DVW'(tpu_eff) * DVW'(erta_pkg::CM_DIVISOR);
               div_cnt_in   = '0;
               state_in     = stamps_good ? erta_pkg::ST_DIST : erta_pkg::ST_UPDATE;
            end
         end
         erta_pkg::ST_DIST, erta_pkg::ST_AVG: begin
            div_quo_in = step_quo;
            div_rem_in = step_rem;
            div_cnt_in = div_cnt_ff + erta_pkg::DIV_CNT_W'(1);
            if (div_last) begin
               state_in = (state_ff == erta_pkg::ST_DIST)
                          ? erta_pkg::ST_UPDATE : erta_pkg::ST_EMIT;
            end
         end
         erta_pkg::ST_UPDATE: begin
            if (slot_good_ff) begin
               running_sum_in = running_sum_ff + SUM_W'(dist_sat);
               good_count_in  = good_count_ff + CNW'(1);
               if (dist_sat < smallest_ff) smallest_in = dist_sat;
               if (dist_sat > largest_ff)  largest_in  = dist_sat;
            end
            slot_count_in = slot_count_ff + CNW'(1);
            state_in      = erta_pkg::ST_CHECK;
         end
         erta_pkg::ST_CHECK: begin
            if (!window_closed) begin
               state_in = erta_pkg::ST_IDLE;
            end else if (good_count_ff < CNW'(2)) begin
               few_in   = 1'b1;
               state_in = erta_pkg::ST_EMIT;
            end else begin
               few_in     = 1'b0;
               div_quo_in = STW'(trimmed);
               div_rem_in = '0;
               div_dsr_in = DVW'(n_eff);
               div_cnt_in = '0;
               state_in   = erta_pkg::ST_AVG;
            end
         end
         erta_pkg::ST_EMIT: begin
            // hold until the output register can take the word
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_dist_in    = few_ff ? '0 : avg_sat;
               rsp_count_in   = good_count_ff;
               rsp_few_in     = few_ff;
               slot_count_in  = '0;
               running_sum_in = '0;
               smallest_in    = DIST_W'(MAX_DISTANCE_CM);
               largest_in     = '0;
               good_count_in  = '0;
               state_in       = erta_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = erta_pkg::ST_IDLE;
         end
      endcase
   end

   // control and window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= erta_pkg::ST_IDLE;
         avg_count_ff    <= erta_pkg::AVG_COUNT_RST;
         ticks_per_us_ff <= erta_pkg::TICKS_PER_US_RST;
         slot_count_ff   <= '0;
         running_sum_ff  <= '0;
         smallest_ff     <= DIST_W'(MAX_DISTANCE_CM);
         largest_ff      <= '0;
         good_count_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         slot_count_ff  <= slot_count_in;
         running_sum_ff <= running_sum_in;
         smallest_ff    <= smallest_in;
         largest_ff     <= largest_in;
         good_count_ff  <= good_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               erta_pkg::CSR_AVG_COUNT: begin
                  avg_count_ff <= csr_data[erta_pkg::NUM_W-1:0];
               end
               erta_pkg::CSR_TICKS_PER_US: begin
                  ticks_per_us_ff <= csr_data[erta_pkg::TPU_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      slot_good_ff <= slot_good_in;
      few_ff       <= few_in;
      div_quo_ff   <= div_quo_in;
      div_rem_ff   <= div_rem_in;
      div_dsr_ff   <= div_dsr_in;
      div_cnt_ff   <= div_cnt_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_count_ff <= rsp_count_in;
      rsp_few_ff   <= rsp_few_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_distance_cm   = rsp_dist_ff;
   assign rsp_valid_samples = rsp_count_ff;
   assign rsp_too_few       = rsp_few_ff;

`ifndef SYNTHESIS
   // a slot keeps the sequencer busy for at least the cycle after accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("req_ready right after an accepted word");

   // the average division always leads to loading the output
   a_avg_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == erta_pkg::ST_AVG && div_last) |=> (state_ff == erta_pkg::ST_EMIT))
      else $error("average division did not end in emit");

   // too_few words carry zero distance
   a_few_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_too_few) |-> (rsp_distance_cm == '0))
      else $error("too_few word with nonzero distance");

   // a trimmed result needs at least two valid samples
   a_enough_samples: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_too_few) |-> (rsp_valid_samples >= CNW'(2)))
      else $error("trimmed result with fewer than two samples");

   // valid samples never outnumber slots in the window
   a_good_le_slots: assert property (@(posedge clock) disable iff (reset)
      good_count_ff <= slot_count_ff)
      else $error("good count above slot count");
`endif

endmodule
